>>> design/ggc_pkg.sv
// Shared types, sizes and state encoding for the greedy graph coloring block.
// Used by every file in the design folder except ggc_ram; depends on nothing.
package ggc_pkg;

    // Graph and palette sizes.
    localparam int unsigned NUM_NODES  = 1024;
    localparam int unsigned NUM_COLORS = 1024;

    // Fixed field widths of the channels and the configuration register.
    localparam int unsigned CFG_W = 11;
    localparam int unsigned NBR_W = 10;
    localparam int unsigned OUT_W = 10;

    // Derived widths.
    localparam int unsigned NW         = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int unsigned CNW        = NW + 1;
    localparam int unsigned CW         = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
    localparam int unsigned WORD_BITS  = 64;
    localparam int unsigned BIT_W      = 6;
    localparam int unsigned USED_WORDS = (NUM_COLORS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WAW        = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;

    typedef logic [CW-1:0]        t_color;
    typedef logic [NW-1:0]        t_node;
    typedef logic [CNW-1:0]       t_node_cnt;
    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WAW-1:0]       t_waddr;
    typedef logic [BIT_W-1:0]     t_bit;

    // One color table entry: colored flag and color.
    typedef struct packed {
        logic   colored;
        t_color color;
    } t_ctab;

    // Color table access from the core.
    typedef struct packed {
        logic  we;
        t_node waddr;
        t_ctab wdata;
        t_node raddr;
    } t_ctab_req;

    // Used-color bitmap access from the core.
    typedef struct packed {
        logic   we;
        t_waddr waddr;
        t_word  wdata;
        t_waddr raddr;
    } t_bmp_req;

    // Lowest free color within one bitmap word.
    typedef struct packed {
        logic found;
        t_bit idx;
    } t_find;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_MARK,
        ST_SCAN,
        ST_EMIT,
        ST_CLEAR
    } t_state;

endpackage

>>> design/ggc_if.sv
// Valid/ready channel interfaces for neighbor items and coloring results.
// Depends on ggc_pkg for the field widths.
interface ggc_nbr_if;
    import ggc_pkg::*;

    logic             valid;
    logic             ready;
    logic [NBR_W-1:0] neighbor_id;
    logic             neighbor_valid;
    logic             last_neighbor;

    modport source (output valid, neighbor_id, neighbor_valid, last_neighbor, input ready);
    modport sink   (input valid, neighbor_id, neighbor_valid, last_neighbor, output ready);
endinterface

interface ggc_res_if;
    import ggc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] node_index;
    logic [OUT_W-1:0] assigned_color;
    logic             status;

    modport source (output valid, node_index, assigned_color, status, input ready);
    modport sink   (input valid, node_index, assigned_color, status, output ready);
endinterface

>>> design/ggc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ggc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read; a read of the address being written returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/ggc_find.sv
// Lowest free color within one 64-bit word of the used-color bitmap.
// Depends on ggc_pkg; bits beyond the palette count as used.
module ggc_find (
    input  ggc_pkg::t_word  i_word,
    input  ggc_pkg::t_waddr i_widx,
    output ggc_pkg::t_find  o_res
);
    import ggc_pkg::*;

    // Priority search from the top bit down so the lowest free bit wins.
    always_comb begin
        o_res = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!i_word[b] && (((32'(i_widx) << BIT_W) + 32'(b)) < NUM_COLORS)) begin
                o_res.found = 1'b1;
                o_res.idx   = BIT_W'(b);
            end
        end
    end
endmodule

>>> design/ggc_core.sv
// Coloring sequencer: neighbor lookup, bitmap read-modify-write, first-free scan.
// Depends on ggc_pkg, ggc_if and ggc_find; the two RAMs sit in the top level.
module ggc_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ggc_pkg::CFG_W-1:0]  i_cfg_wdata,
    ggc_nbr_if.sink                    i_nbr,
    ggc_res_if.source                  o_res,
    output ggc_pkg::t_ctab_req         o_ctab_req,
    input  ggc_pkg::t_ctab             i_ctab_rdata,
    output ggc_pkg::t_bmp_req          o_bmp_req,
    input  ggc_pkg::t_word             i_bmp_rdata
);
    import ggc_pkg::*;

    t_state          r_state;
    t_state          n_state;
    logic [CFG_W-1:0] r_node_count;
    t_node_cnt       r_cur_node;
    logic            r_hit;
    logic            r_last;
    logic            r_mark;
    t_waddr          r_mark_word;
    t_bit            r_mark_bit;
    logic [WAW:0]    r_rd_word;
    logic            r_chk_vld;
    t_waddr          r_chk_word;
    logic            r_found;
    t_color          r_pick;
    logic            r_out_valid;
    logic [OUT_W-1:0] r_out_node;
    logic [OUT_W-1:0] r_out_color;
    logic            r_out_status;
    t_waddr          r_clr_word;

    logic   active;
    logic   in_ready;
    logic   accept;
    logic   hit_in;
    logic   out_free;
    logic   emit_go;
    logic   rd_more;
    t_find  find_res;

    // The run is live while the current node is below both the count and the table size.
    assign active = (32'(r_cur_node) < 32'(r_node_count)) && (32'(r_cur_node) < NUM_NODES);
    assign accept = i_nbr.valid && in_ready;

    // A neighbor counts only if real, in range and already visited (entry written).
    assign hit_in = i_nbr.neighbor_valid
                 && (32'(i_nbr.neighbor_id) < NUM_NODES)
                 && (32'(i_nbr.neighbor_id) < 32'(r_cur_node));

    assign out_free = !r_out_valid || o_res.ready;
    assign emit_go  = (r_state == ST_EMIT) && out_free;
    assign rd_more  = 32'(r_rd_word) < USED_WORDS;

    ggc_find u_find (
        .i_word (i_bmp_rdata),
        .i_widx (r_chk_word),
        .o_res  (find_res)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_word == WAW'(USED_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && active) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_MARK;
            end
            ST_MARK: begin
                if (r_last) begin
                    n_state = ST_SCAN;
                end else if (accept && active) begin
                    n_state = ST_LOOKUP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_chk_vld && (r_chk_word == WAW'(USED_WORDS - 1))) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory requests.
    always_comb begin
        in_ready         = 1'b0;
        o_ctab_req       = '0;
        o_ctab_req.raddr = NW'(i_nbr.neighbor_id);
        o_bmp_req        = '0;
        case (r_state)
            ST_CLEAR: begin
                // Zero one bitmap word per cycle after reset.
                o_bmp_req.we    = 1'b1;
                o_bmp_req.waddr = r_clr_word;
                o_bmp_req.wdata = '0;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_LOOKUP: begin
                o_bmp_req.raddr = WAW'(32'(i_ctab_rdata.color) >> BIT_W);
            end
            ST_MARK: begin
                in_ready        = !r_last;
                o_bmp_req.we    = r_mark;
                o_bmp_req.waddr = r_mark_word;
                o_bmp_req.wdata = i_bmp_rdata | (WORD_BITS'(1) << r_mark_bit);
            end
            ST_SCAN: begin
                // Read the next word while clearing the one just checked.
                o_bmp_req.raddr = r_rd_word[WAW-1:0];
                o_bmp_req.we    = r_chk_vld;
                o_bmp_req.waddr = r_chk_word;
                o_bmp_req.wdata = '0;
            end
            ST_EMIT: begin
                o_ctab_req.we            = out_free;
                o_ctab_req.waddr         = NW'(r_cur_node);
                o_ctab_req.wdata.colored = r_found;
                o_ctab_req.wdata.color   = r_pick;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_node_count <= '0;
            r_cur_node   <= '0;
            r_last       <= 1'b0;
            r_mark       <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_clr_word   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_word <= r_clr_word + WAW'(1);
            end
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (accept) begin
                r_last <= i_nbr.last_neighbor;
            end
            if (r_state == ST_LOOKUP) begin
                r_mark <= r_hit && i_ctab_rdata.colored;
            end
            if ((r_state == ST_MARK) && r_last) begin
                r_chk_vld <= 1'b0;
                r_found   <= 1'b0;
            end
            if (r_state == ST_SCAN) begin
                r_chk_vld <= rd_more;
                if (r_chk_vld && !r_found && find_res.found) begin
                    r_found <= 1'b1;
                end
            end
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
                r_cur_node  <= r_cur_node + CNW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit <= hit_in;
        end
        if (r_state == ST_LOOKUP) begin
            r_mark_word <= WAW'(32'(i_ctab_rdata.color) >> BIT_W);
            r_mark_bit  <= BIT_W'(i_ctab_rdata.color);
        end
        if ((r_state == ST_MARK) && r_last) begin
            r_rd_word <= '0;
            r_pick    <= '0;
        end
        if (r_state == ST_SCAN) begin
            if (rd_more) begin
                r_rd_word <= r_rd_word + (WAW + 1)'(1);
            end
            r_chk_word <= r_rd_word[WAW-1:0];
            if (r_chk_vld && !r_found && find_res.found) begin
                r_pick <= CW'((32'(r_chk_word) << BIT_W) | 32'(find_res.idx));
            end
        end
        if (emit_go) begin
            r_out_node   <= OUT_W'(r_cur_node);
            r_out_color  <= OUT_W'(r_pick);
            r_out_status <= !r_found;
        end
    end

    assign i_nbr.ready          = in_ready;
    assign o_res.valid          = r_out_valid;
    assign o_res.node_index     = r_out_node;
    assign o_res.assigned_color = r_out_color;
    assign o_res.status         = r_out_status;
endmodule

>>> design/greedy_graph_coloring.sv
// First-fit greedy graph coloring. Nodes 0 to node_count-1 are colored in order; each
// neighbor transaction looks up the neighbor's color and marks it in a used-color bitmap,
// and the transaction flagged last_neighbor picks the lowest free color and returns one
// result. A neighbor transaction is handled as one color-table read, then one bitmap
// read-modify-write, and the next transaction is taken in the write cycle. For the last
// transaction of a node the bitmap is scanned and cleared one 64-bit word per cycle, then
// the result is stored and issued. After reset the bitmap is zeroed one word per cycle,
// and no transaction is taken until it is clear.
// The color table needs no clearing after reset: entries below the current node are always
// written, and only those are used. Depends on ggc_pkg, ggc_if, ggc_ram, ggc_core.
module greedy_graph_coloring (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ggc_pkg::CFG_W-1:0] i_cfg_wdata,
    ggc_nbr_if.sink                   i_nbr,
    ggc_res_if.source                 o_res
);
    import ggc_pkg::*;

    t_ctab_req ctab_req;
    t_ctab     ctab_rdata;
    t_bmp_req  bmp_req;
    t_word     bmp_rdata;

    // Per-node colored flag and color.
    ggc_ram #(
        .WIDTH ($bits(t_ctab)),
        .DEPTH (NUM_NODES)
    ) u_ctab_ram (
        .i_clk   (i_clk),
        .i_we    (ctab_req.we),
        .i_waddr (ctab_req.waddr),
        .i_wdata (ctab_req.wdata),
        .i_raddr (ctab_req.raddr),
        .o_rdata (ctab_rdata)
    );

    // Used-color bitmap of the node in progress.
    ggc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (USED_WORDS)
    ) u_bmp_ram (
        .i_clk   (i_clk),
        .i_we    (bmp_req.we),
        .i_waddr (bmp_req.waddr),
        .i_wdata (bmp_req.wdata),
        .i_raddr (bmp_req.raddr),
        .o_rdata (bmp_rdata)
    );

    ggc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_nbr        (i_nbr),
        .o_res        (o_res),
        .o_ctab_req   (ctab_req),
        .i_ctab_rdata (ctab_rdata),
        .o_bmp_req    (bmp_req),
        .i_bmp_rdata  (bmp_rdata)
    );
endmodule

>>> design/ggc_checker.sv
// Port-level checks for greedy_graph_coloring, attached by the bind below.
// Depends on ggc_pkg and on the top level's ports.
module ggc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [ggc_pkg::OUT_W-1:0] i_node_index,
    input logic [ggc_pkg::OUT_W-1:0] i_assigned_color,
    input logic                      i_status
);
    import ggc_pkg::*;

    logic [OUT_W-1:0] r_exp_node;

    // Results come out for nodes 0, 1, 2, ... in order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_node <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_exp_node <= r_exp_node + OUT_W'(1);
        end
    end

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_node_index)
            && $stable(i_assigned_color) && $stable(i_status))
        else $error("result changed while stalled");

    // An uncolored node reports color zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_assigned_color == '0)
        else $error("nonzero color with status set");

    // A new result is issued only from the end-of-node phase, where no input is taken.
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result issued while taking neighbors");

    // Node indices follow the coloring order.
    a_node_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_node_index == r_exp_node)
        else $error("result node out of order");
endmodule

bind greedy_graph_coloring ggc_checker u_ggc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_nbr.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_node_index     (o_res.node_index),
    .i_assigned_color (o_res.assigned_color),
    .i_status         (o_res.status)
);

>>> dv/tb_greedy_graph_coloring.sv
// Self-checking testbench for greedy_graph_coloring: streams neighbor transactions,
// predicts each coloring result and checks the result channel against it.
// Depends on ggc_pkg, ggc_if and the design files under the design folder.
module tb_greedy_graph_coloring;
    import ggc_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned CLIQUE_NODES = 20;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned STALL_LIMIT  = 5000;

    localparam logic STATUS_COLORED  = 1'b0;
    localparam logic STATUS_NO_COLOR = 1'b1;

    // One neighbor transaction and one coloring result.
    typedef struct packed {
        logic [NBR_W-1:0] nid;
        logic             nvalid;
        logic             last;
    } t_nbr_item;

    typedef struct packed {
        logic [OUT_W-1:0] node;
        logic [OUT_W-1:0] color;
        logic             status;
    } t_coloring;

    typedef enum int {
        SINK_OPEN,
        SINK_LIGHT,
        SINK_HEAVY,
        SINK_PERIODIC
    } t_sink_mode;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    ggc_nbr_if nbr_ch ();
    ggc_res_if res_ch ();

    greedy_graph_coloring u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_nbr       (nbr_ch),
        .o_res       (res_ch)
    );

    // Stimulus and expectation stores.
    t_nbr_item   nbr_pending [$];
    t_coloring   color_expect [$];
    int unsigned mismatches;
    int unsigned stall_cycles;
    logic        nbr_took;

    // Predicted block state.
    int unsigned           node_limit;
    int unsigned           cur_node;
    bit                    node_colored [NUM_NODES];
    t_color                node_color [NUM_NODES];
    bit [NUM_COLORS-1:0]   color_taken;

    // Generator bookkeeping.
    int unsigned gen_node;
    int unsigned rand_items;

    // Driver and sink pattern state.
    t_nbr_item   src_item;
    int unsigned src_burst;
    int unsigned src_gap;
    t_sink_mode  sink_mode;
    int unsigned sink_hold;
    logic        sink_next;

    always #5 i_clk = ~i_clk;

    // Applies one accepted neighbor transaction to the predicted state.
    function automatic void color_neighbor(input t_nbr_item it);
        t_coloring   outcome;
        int unsigned pick;
        bit          found;
        found = 1'b0;
        pick  = 0;
        if (cur_node >= node_limit || cur_node >= NUM_NODES) return;
        if (it.nvalid && node_colored[it.nid]) color_taken[node_color[it.nid]] = 1'b1;
        if (!it.last) return;
        for (int c = 0; c < NUM_COLORS; c++) begin
            if (!color_taken[c]) begin
                found = 1'b1;
                pick  = c;
                break;
            end
        end
        if (found) begin
            node_colored[cur_node] = 1'b1;
            node_color[cur_node]   = t_color'(pick);
        end
        outcome.node   = OUT_W'(cur_node);
        outcome.color  = found ? OUT_W'(pick) : '0;
        outcome.status = found ? STATUS_COLORED : STATUS_NO_COLOR;
        color_expect.push_back(outcome);
        color_taken = '0;
        cur_node    = cur_node + 1;
    endfunction

    // Compares one accepted result with the oldest expected coloring.
    function automatic void check_coloring(input t_coloring got);
        t_coloring want;
        if (color_expect.size() == 0) begin
            $display("%0t: unexpected result: node %0d color %0d status %0d",
                     $time, got.node, got.color, got.status);
            mismatches++;
        end else begin
            want = color_expect.pop_front();
            if (got.node !== want.node || got.color !== want.color ||
                got.status !== want.status) begin
                $display("%0t: mismatch: expected node %0d color %0d status %0d, got node %0d color %0d status %0d",
                         $time, want.node, want.color, want.status,
                         got.node, got.color, got.status);
                mismatches++;
            end
        end
    endfunction

    // Picks a neighbor id: mostly an already colored node, sometimes one not yet colored.
    function automatic logic [NBR_W-1:0] pick_neighbor();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7 && gen_node > 0) return NBR_W'($urandom_range(0, gen_node - 1));
        if (r < 9) return NBR_W'($urandom_range(gen_node, NUM_NODES - 1));
        return NBR_W'($urandom_range(0, NUM_NODES - 1));
    endfunction

    task automatic push_item(input logic [NBR_W-1:0] id, input logic ok, input logic last);
        nbr_pending.push_back('{id, ok, last});
    endtask

    // Queues one node with a random neighbor list, the final transaction flagged last.
    task automatic queue_random_node();
        int unsigned degree;
        degree = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        for (int unsigned k = 0; k < degree; k++)
            push_item(pick_neighbor(), $urandom_range(0, 4) != 0, k == degree - 1);
        rand_items += degree;
        gen_node++;
    endtask

    // Queues one clique member: adjacent to every earlier member, in rotated order.
    task automatic queue_clique_node(input int unsigned base);
        int unsigned members;
        int unsigned start;
        members = gen_node - base;
        if (members == 0) begin
            push_item(pick_neighbor(), 1'b0, 1'b1);
            rand_items++;
        end else begin
            if ($urandom_range(0, 2) == 0) begin
                push_item(pick_neighbor(), 1'($urandom_range(0, 1)), 1'b0);
                rand_items++;
            end
            start = $urandom_range(0, members - 1);
            for (int unsigned k = 0; k < members; k++)
                push_item(NBR_W'(base + (start + k) % members), 1'b1, k == members - 1);
            rand_items += members;
        end
        gen_node++;
    endtask

    // Waits until every transaction is sent and every result is back, then lets the
    // block finish any work that produces no result.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (nbr_pending.size() != 0 || nbr_ch.valid || color_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_node_count(input int unsigned count);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(count);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Ends a phase with dropped transactions, a node left half fed, or nothing extra.
    task automatic close_phase();
        int unsigned n;
        case ($urandom_range(0, 2))
            0: begin
                repeat ($urandom_range(1, 3))
                    push_item(pick_neighbor(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end
            1: begin
                if (gen_node < NUM_NODES) begin
                    wait_idle();
                    write_node_count(gen_node + 1);
                    n = $urandom_range(1, 3);
                    repeat (n) push_item(pick_neighbor(), 1'b1, 1'b0);
                    rand_items += n;
                end
            end
            default: ;
        endcase
        wait_idle();
    endtask

    // Driver: presents queued transactions in bursts separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            nbr_ch.valid <= 1'b0;
        end else if (!nbr_ch.valid || nbr_took) begin
            if (src_gap != 0) begin
                src_gap--;
                nbr_ch.valid <= 1'b0;
            end else if (nbr_pending.size() != 0) begin
                src_item = nbr_pending.pop_front();
                nbr_ch.valid          <= 1'b1;
                nbr_ch.neighbor_id    <= src_item.nid;
                nbr_ch.neighbor_valid <= src_item.nvalid;
                nbr_ch.last_neighbor  <= src_item.last;
                if (src_burst != 0) begin
                    src_burst--;
                end else begin
                    src_burst = $urandom_range(0, 30);
                    src_gap   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 16)
                                                            : $urandom_range(0, 4);
                end
            end else begin
                nbr_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink: ready follows a pattern that switches mode every so often.
    always @(negedge i_clk) begin
        if (sink_hold == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            sink_hold = $urandom_range(8, 120);
        end else begin
            sink_hold--;
        end
        case (sink_mode)
            SINK_OPEN:  sink_next = 1'b1;
            SINK_LIGHT: sink_next = ($urandom_range(0, 3) != 0);
            SINK_HEAVY: sink_next = ($urandom_range(0, 3) == 0);
            default:    sink_next = ((sink_hold % 16) < 12);
        endcase
        res_ch.ready <= i_rst_n && sink_next;
    end

    // Monitor: tracks configuration writes, predicts on accepted neighbor transactions,
    // checks accepted results and watches for a stuck block.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) node_limit = i_cfg_wdata;
            if (nbr_ch.valid && nbr_ch.ready)
                color_neighbor('{nbr_ch.neighbor_id, nbr_ch.neighbor_valid,
                                 nbr_ch.last_neighbor});
            if (res_ch.valid && res_ch.ready)
                check_coloring('{res_ch.node_index, res_ch.assigned_color, res_ch.status});
        end
        nbr_took <= i_rst_n && nbr_ch.valid && nbr_ch.ready;
        if ((nbr_ch.valid && nbr_ch.ready) || (res_ch.valid && res_ch.ready) || i_cfg_we)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus sequence: directed cases first, then phases of random graphs.
    initial begin
        int unsigned phase_end;
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = '0;
        nbr_ch.valid          = 1'b0;
        nbr_ch.neighbor_id    = '0;
        nbr_ch.neighbor_valid = 1'b0;
        nbr_ch.last_neighbor  = 1'b0;
        res_ch.ready          = 1'b0;
        nbr_took              = 1'b0;
        mismatches            = 0;
        stall_cycles          = 0;
        node_limit            = 0;
        cur_node              = 0;
        color_taken           = '0;
        gen_node              = 0;
        rand_items            = 0;
        src_burst             = 0;
        src_gap               = 0;
        sink_mode             = SINK_OPEN;
        sink_hold             = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With node_count still at its reset value of zero, everything is dropped.
        push_item(10'd0, 1'b1, 1'b1);
        push_item(10'd1023, 1'b0, 1'b1);
        wait_idle();
        write_node_count(0);
        push_item(10'd512, 1'b1, 1'b1);
        wait_idle();

        // Small hand-built graph: no neighbors, a chain, self and later neighbors,
        // an invalid neighbor naming a colored node, and repeated neighbors.
        write_node_count(6);
        push_item(10'd1023, 1'b0, 1'b1);
        push_item(10'd0, 1'b1, 1'b1);
        push_item(10'd1, 1'b1, 1'b0);
        push_item(10'd0, 1'b1, 1'b1);
        push_item(10'd3, 1'b1, 1'b0);
        push_item(10'd1023, 1'b1, 1'b0);
        push_item(10'd2, 1'b1, 1'b1);
        push_item(10'd0, 1'b0, 1'b0);
        push_item(10'd3, 1'b1, 1'b0);
        push_item(10'd0, 1'b1, 1'b0);
        push_item(10'd1, 1'b1, 1'b1);
        push_item(10'd4, 1'b1, 1'b0);
        push_item(10'd2, 1'b1, 1'b0);
        push_item(10'd1, 1'b1, 1'b0);
        push_item(10'd3, 1'b1, 1'b0);
        push_item(10'd5, 1'b1, 1'b1);
        // Past the last node: dropped.
        push_item(10'd0, 1'b1, 1'b1);
        push_item(10'd1, 1'b1, 1'b0);
        gen_node = 6;
        wait_idle();

        // Lowering node_count below the current node keeps dropping transactions.
        write_node_count(3);
        push_item(10'd0, 1'b1, 1'b1);
        push_item(10'd5, 1'b1, 1'b1);
        wait_idle();

        // A clique drives the picked color well above the low values.
        phase_end = gen_node + CLIQUE_NODES + 4;
        write_node_count(phase_end);
        phase_end = gen_node;
        repeat (CLIQUE_NODES) queue_clique_node(phase_end);
        while (gen_node < phase_end + CLIQUE_NODES + 4) queue_random_node();
        close_phase();

        // Random graphs, one node_count setting per phase.
        while (rand_items < RANDOM_ITEMS && gen_node < NUM_NODES - 64) begin
            phase_end = gen_node + $urandom_range(8, 48);
            write_node_count(phase_end);
            while (gen_node < phase_end) queue_random_node();
            close_phase();
        end

        // Largest node_count to finish.
        write_node_count(NUM_NODES);
        repeat (12) queue_random_node();
        wait_idle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
design/ggc_pkg.sv
design/ggc_if.sv
design/ggc_ram.sv
design/ggc_find.sv
design/ggc_core.sv
design/greedy_graph_coloring.sv
design/ggc_checker.sv
dv/tb_greedy_graph_coloring.sv
